// ----- rtl/sos_pkg.sv -----
package sos_pkg;

    localparam int MAX_ROWS    = 8;
    localparam int MAX_COLS    = 8;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

    localparam int DATA_W    = 32;
    localparam int DIM_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_W    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int TOT_W     = 2 * DIM_W;

    localparam logic [DIM_W-1:0] MAX_ROWS_D = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0] MAX_COLS_D = DIM_W'(MAX_COLS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

    typedef enum logic {
        ST_LOAD,
        ST_WALK
    } t_state;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } t_dir;

    typedef struct packed {
        logic wr_en;
        logic walk_init;
        logic rd_en;
    } t_cmd;

    typedef struct packed {
        logic load_final;
        logic walk_final;
    } t_status;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ----- rtl/sos_if.sv -----
interface sos_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [sos_pkg::DATA_W-1:0]  element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface sos_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sos_pkg::DATA_W-1:0]  out_value;
    logic                               is_last;

    modport source (output valid, output out_value, output is_last, input ready);
    modport sink   (input valid, input out_value, input is_last, output ready);
endinterface

interface sos_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sos_pkg::CFG_IDX_W-1:0]      index;
    logic [sos_pkg::DIM_W-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/sos_ctrl.sv -----
module sos_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    input  sos_pkg::t_status    i_status,
    output sos_pkg::t_cmd       o_cmd,
    output logic                o_in_ready,
    output logic                o_out_valid
);

    sos_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sos_pkg::ST_LOAD: begin
                if (i_in_valid && i_status.load_final) begin
                    n_state = sos_pkg::ST_WALK;
                end
            end
            sos_pkg::ST_WALK: begin
                if (o_cmd.rd_en && i_status.walk_final) begin
                    n_state = sos_pkg::ST_LOAD;
                end
            end
            default: n_state = sos_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            sos_pkg::ST_LOAD: begin
                o_in_ready      = 1'b1;
                o_cmd.wr_en     = i_in_valid;
                o_cmd.walk_init = i_in_valid && i_status.load_final;
            end
            sos_pkg::ST_WALK: begin
                // read the next element whenever the output slot frees up
                o_cmd.rd_en = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.rd_en) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sos_pkg::ST_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_init_enters_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.walk_init |=> r_state == sos_pkg::ST_WALK)
        else $error("walk did not start after final element");

    a_final_read_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.rd_en && i_status.walk_final) |=> (r_state == sos_pkg::ST_LOAD && r_out_valid))
        else $error("walk did not end after final read");
`endif

endmodule

// ----- rtl/sos_datapath.sv -----
module sos_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sos_pkg::t_cmd                       i_cmd,
    output sos_pkg::t_status                    o_status,
    input  logic signed [sos_pkg::DATA_W-1:0]   i_element_value,
    input  logic                                i_cfg_valid,
    input  logic [sos_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sos_pkg::DIM_W-1:0]           i_cfg_data,
    output logic signed [sos_pkg::DATA_W-1:0]   o_out_value,
    output logic                                o_is_last
);

    logic [sos_pkg::DATA_W-1:0] r_store [sos_pkg::STORE_DEPTH];

    logic [sos_pkg::DIM_W-1:0]  r_row_count, r_col_count;
    logic [sos_pkg::DIM_W-1:0]  rows_c, cols_c;
    logic [sos_pkg::TOT_W-1:0]  total;
    logic [sos_pkg::ADDR_W-1:0] r_load_count;

    logic [sos_pkg::ROW_W-1:0]  r_top, r_bottom, r_row;
    logic [sos_pkg::COL_W-1:0]  r_left, r_right, r_col;
    sos_pkg::t_dir              r_dir;
    logic [sos_pkg::ROW_W-1:0]  n_top, n_bottom, n_row;
    logic [sos_pkg::COL_W-1:0]  n_left, n_right, n_col;
    sos_pkg::t_dir              n_dir;

    logic                       side_end, walk_done;
    logic [sos_pkg::TOT_W-1:0]  addr_full;
    logic [sos_pkg::ADDR_W-1:0] rd_addr;

    logic [sos_pkg::DATA_W-1:0] r_rd_data;
    logic                       r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= sos_pkg::MAX_ROWS_D;
            r_col_count <= sos_pkg::MAX_COLS_D;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sos_pkg::REG_ROW_COUNT: r_row_count <= i_cfg_data;
                sos_pkg::REG_COL_COUNT: r_col_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign rows_c = sos_pkg::clamp_dim(r_row_count, sos_pkg::MAX_ROWS_D);
    assign cols_c = sos_pkg::clamp_dim(r_col_count, sos_pkg::MAX_COLS_D);
    assign total  = sos_pkg::TOT_W'(rows_c) * sos_pkg::TOT_W'(cols_c);

    assign o_status.load_final =
        (sos_pkg::TOT_W'(r_load_count) + sos_pkg::TOT_W'(1)) >= total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
        end else if (i_cmd.wr_en) begin
            r_load_count <= o_status.load_final ? '0 : r_load_count + 1'b1;
        end
    end

    // next position and bounds; a bound only moves at the end of its side
    always_comb begin
        n_top    = r_top;
        n_bottom = r_bottom;
        n_left   = r_left;
        n_right  = r_right;
        n_row    = r_row;
        n_col    = r_col;
        n_dir    = r_dir;
        case (r_dir)
            sos_pkg::DIR_RIGHT: begin
                side_end  = (r_col == r_right);
                walk_done = (r_top >= r_bottom);
                if (!side_end) begin
                    n_col = r_col + 1'b1;
                end else begin
                    n_top = r_top + 1'b1;
                    n_row = r_top + 1'b1;
                    n_dir = sos_pkg::DIR_DOWN;
                end
            end
            sos_pkg::DIR_DOWN: begin
                side_end  = (r_row == r_bottom);
                walk_done = (r_right <= r_left);
                if (!side_end) begin
                    n_row = r_row + 1'b1;
                end else begin
                    n_right = r_right - 1'b1;
                    n_col   = r_right - 1'b1;
                    n_dir   = sos_pkg::DIR_LEFT;
                end
            end
            sos_pkg::DIR_LEFT: begin
                side_end  = (r_col == r_left);
                walk_done = (r_bottom <= r_top);
                if (!side_end) begin
                    n_col = r_col - 1'b1;
                end else begin
                    n_bottom = r_bottom - 1'b1;
                    n_row    = r_bottom - 1'b1;
                    n_dir    = sos_pkg::DIR_UP;
                end
            end
            sos_pkg::DIR_UP: begin
                side_end  = (r_row == r_top);
                walk_done = (r_left >= r_right);
                if (!side_end) begin
                    n_row = r_row - 1'b1;
                end else begin
                    n_left = r_left + 1'b1;
                    n_col  = r_left + 1'b1;
                    n_dir  = sos_pkg::DIR_RIGHT;
                end
            end
            default: begin
                side_end  = 1'b1;
                walk_done = 1'b1;
            end
        endcase
    end

    assign o_status.walk_final = side_end && walk_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= '0;
            r_bottom <= '0;
            r_left   <= '0;
            r_right  <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_dir    <= sos_pkg::DIR_RIGHT;
        end else if (i_cmd.walk_init) begin
            r_top    <= '0;
            r_bottom <= sos_pkg::ROW_W'(rows_c - 1'b1);
            r_left   <= '0;
            r_right  <= sos_pkg::COL_W'(cols_c - 1'b1);
            r_row    <= '0;
            r_col    <= '0;
            r_dir    <= sos_pkg::DIR_RIGHT;
        end else if (i_cmd.rd_en) begin
            r_top    <= n_top;
            r_bottom <= n_bottom;
            r_left   <= n_left;
            r_right  <= n_right;
            r_row    <= n_row;
            r_col    <= n_col;
            r_dir    <= n_dir;
        end
    end

    assign addr_full = sos_pkg::TOT_W'(r_row) * sos_pkg::TOT_W'(cols_c)
                     + sos_pkg::TOT_W'(r_col);
    assign rd_addr   = addr_full[sos_pkg::ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_store[r_load_count] <= i_element_value;
        end
    end

    // read data register doubles as the output register; hold it while stalled
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_store[rd_addr];
            r_last    <= o_status.walk_final;
        end
    end

    assign o_out_value = r_rd_data;
    assign o_is_last   = r_last;

`ifndef NO_ASSERTIONS
    a_pos_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (r_row >= r_top && r_row <= r_bottom
                         && r_col >= r_left && r_col <= r_right))
        else $error("spiral position outside boundaries");

    a_addr_in_matrix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> addr_full < total)
        else $error("spiral read beyond loaded matrix");
`endif

endmodule

// ----- rtl/spiral_order_scanner.sv -----
// Loads one element per cycle outside the walk; no result until the element that completes the matrix.
// The spiral walk then reads the element store once per cycle while the output slot is free:
// after the final element transfer the walk state is entered, then the first read fills the output
// register; an R x C matrix is loaded in full before its walk, and the store has one read port.
// Reset (synchronous, active low) clears the load count, walk state and output valid, and sets
// both dimensions to 8; element store contents are not cleared.
module spiral_order_scanner (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sos_in_if.sink          i_in,
    sos_out_if.source       o_out,
    sos_cfg_if.sink         i_cfg
);

    sos_pkg::t_cmd    cmd;
    sos_pkg::t_status status;
    logic             in_ready;
    logic             out_valid;

    sos_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid)
    );

    sos_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_element_value (i_in.element_value),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_out_value     (o_out.out_value),
        .o_is_last       (o_out.is_last)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign i_cfg.ready = 1'b1;

endmodule

// ----- verif/spiral_order_scanner_tb.sv -----
module spiral_order_scanner_tb;

    localparam int DRAIN_CYCLES = 4;
    localparam int END_CYCLES   = 20;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 100;

    typedef struct {
        logic signed [sos_pkg::DATA_W-1:0] value;
        logic                              last;
    } t_spiral_item;

    class spiral_scoreboard;
        logic [sos_pkg::DATA_W-1:0] element_mem [sos_pkg::STORE_DEPTH];
        logic [6:0]                 load_count;
        logic [sos_pkg::DIM_W-1:0]  row_reg;
        logic [sos_pkg::DIM_W-1:0]  col_reg;
        t_spiral_item               spiral_q [$];
        int                         errors;

        function new();
            load_count = '0;
            row_reg    = sos_pkg::DIM_W'(sos_pkg::MAX_ROWS);
            col_reg    = sos_pkg::DIM_W'(sos_pkg::MAX_COLS);
            errors     = 0;
        endfunction

        function void write_reg(logic [sos_pkg::CFG_IDX_W-1:0] idx,
                                logic [sos_pkg::DIM_W-1:0] data);
            if (idx == sos_pkg::REG_ROW_COUNT) begin
                row_reg = data;
            end else if (idx == sos_pkg::REG_COL_COUNT) begin
                col_reg = data;
            end
        endfunction

        // zero is taken as one, anything past the maximum dimension as the maximum
        function int eff_dim(logic [sos_pkg::DIM_W-1:0] raw, int maxv);
            if (raw == '0) return 1;
            if (int'(raw) > maxv) return maxv;
            return int'(raw);
        endfunction

        function void add_expected(logic signed [sos_pkg::DATA_W-1:0] value, logic last);
            t_spiral_item item;
            item.value = value;
            item.last  = last;
            spiral_q.insert(spiral_q.size(), item);
        endfunction

        function void note_element(logic signed [sos_pkg::DATA_W-1:0] v);
            int rows;
            int cols;
            int top;
            int bottom;
            int left;
            int right;
            int n;
            sos_pkg::t_dir dir;
            logic signed [sos_pkg::DATA_W-1:0] run [sos_pkg::STORE_DEPTH];
            rows = eff_dim(row_reg, sos_pkg::MAX_ROWS);
            cols = eff_dim(col_reg, sos_pkg::MAX_COLS);
            element_mem[load_count % sos_pkg::STORE_DEPTH] = v;
            if (int'(load_count) + 1 < rows * cols) begin
                load_count = load_count + 7'd1;
                return;
            end
            load_count = '0;
            top    = 0;
            left   = 0;
            bottom = rows - 1;
            right  = cols - 1;
            n      = 0;
            dir    = sos_pkg::DIR_RIGHT;
            while (top <= bottom && left <= right) begin
                case (dir)
                    sos_pkg::DIR_RIGHT: begin
                        for (int i = left; i <= right; i++) begin
                            run[n] = element_mem[top * cols + i];
                            n++;
                        end
                        top++;
                    end
                    sos_pkg::DIR_DOWN: begin
                        for (int i = top; i <= bottom; i++) begin
                            run[n] = element_mem[i * cols + right];
                            n++;
                        end
                        right--;
                    end
                    sos_pkg::DIR_LEFT: begin
                        for (int i = right; i >= left; i--) begin
                            run[n] = element_mem[bottom * cols + i];
                            n++;
                        end
                        bottom--;
                    end
                    default: begin
                        for (int i = bottom; i >= top; i--) begin
                            run[n] = element_mem[i * cols + left];
                            n++;
                        end
                        left++;
                    end
                endcase
                dir = dir.next();
            end
            for (int k = 0; k < n; k++) begin
                add_expected(run[k], (k == n - 1));
            end
        endfunction

        function void check_result(logic signed [sos_pkg::DATA_W-1:0] value, logic last);
            t_spiral_item exp_item;
            if (spiral_q.size() == 0) begin
                $error("out_value: expected none, actual %0d", value);
                errors++;
                return;
            end
            exp_item = spiral_q.pop_front();
            if (value !== exp_item.value) begin
                $error("out_value: expected %0d, actual %0d", exp_item.value, value);
                errors++;
            end
            if (last !== exp_item.last) begin
                $error("is_last: expected %0b, actual %0b", exp_item.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return spiral_q.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sos_in_if  in_if ();
    sos_out_if out_if ();
    sos_cfg_if cfg_if ();

    spiral_scoreboard sb = new();

    int  random_items;
    bit  send_quiet;

    spiral_order_scanner u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_result(out_if.out_value, out_if.is_last);
        end
    end

    // output side: stall after a transfer, in bursts that are randomly busy or quiet
    initial begin
        int stall;
        int burst;
        bit quiet;
        burst = 0;
        quiet = 1'b0;
        out_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        out_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                if (burst == 0) begin
                    quiet = ($urandom_range(0, 3) == 0);
                    burst = $urandom_range(4, 16);
                end
                burst--;
                stall = quiet ? 0 : $urandom_range(0, 7);
                if (stall != 0) begin
                    out_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    out_if.ready <= 1'b1;
                end
            end
        end
    end

    function automatic logic signed [sos_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [sos_pkg::DIM_W-1:0] pick_dim();
        int k;
        k = $urandom_range(0, 15);
        if (k == 0) return '0;
        if (k == 1) return sos_pkg::DIM_W'($urandom_range(sos_pkg::MAX_ROWS + 1, 15));
        if (k <= 3) return sos_pkg::DIM_W'($urandom_range(5, sos_pkg::MAX_ROWS));
        return sos_pkg::DIM_W'($urandom_range(1, 4));
    endfunction

    task automatic send_element(input logic signed [sos_pkg::DATA_W-1:0] v);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.element_value <= v;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_element(v);
        random_items++;
    endtask

    task automatic finish_matrix();
        do send_element(pick_value()); while (sb.load_count != 0);
    endtask

    // hold input until the walk has drained and the block has settled
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_dims(input logic [sos_pkg::DIM_W-1:0] rows,
                                input logic [sos_pkg::DIM_W-1:0] cols);
        wait_drain();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= sos_pkg::REG_ROW_COUNT;
        cfg_if.data  <= rows;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(sos_pkg::REG_ROW_COUNT, rows);
        cfg_if.index <= sos_pkg::REG_COL_COUNT;
        cfg_if.data  <= cols;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(sos_pkg::REG_COL_COUNT, cols);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        in_if.valid         <= 1'b0;
        in_if.element_value <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= sos_pkg::REG_ROW_COUNT;
        cfg_if.data         <= '0;
        send_quiet   = 1'b0;
        random_items = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero dimensions act as a 1x1 matrix: one element in, one out
        program_dims('0, '0);
        send_element(32'sh8000_0000);
        send_element(32'sh7fff_ffff);
        send_element('0);
        send_element('1);

        // oversized rows clamp to a single column of eight
        program_dims(4'd15, 4'd1);
        repeat (sos_pkg::MAX_ROWS) send_element(pick_value());

        // oversized columns clamp to a single row of eight
        program_dims(4'd1, 4'd9);
        repeat (sos_pkg::MAX_COLS) send_element(pick_value());

        // shrink mid-load below the count already loaded: next element completes
        program_dims(4'd3, 4'd3);
        repeat (3) send_element(pick_value());
        program_dims(4'd2, 4'd1);
        finish_matrix();

        // full-size matrix first, then random sizes, idling and resizes
        program_dims(sos_pkg::MAX_ROWS_D, sos_pkg::MAX_COLS_D);
        finish_matrix();
        while (random_items < RANDOM_ITEMS) begin
            send_quiet = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 1) == 0) begin
                program_dims(pick_dim(), pick_dim());
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4)) send_element(pick_value());
                program_dims(pick_dim(), pick_dim());
            end
            finish_matrix();
        end

        wait_drain();
        repeat (END_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
